@@ rtl/bra_pkg.sv @@
// Package with shared constants, types and helpers for the rectangle allocator.
package bra_pkg;

    localparam int unsigned ATLAS_SIZE_DEF = 256;
    localparam int unsigned WORD_BITS      = 64;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_TREAD  = 7'b0000100,
        ST_TCHECK = 7'b0001000,
        ST_MREAD  = 7'b0010000,
        ST_MWRITE = 7'b0100000,
        ST_DONE   = 7'b1000000
    } bra_state_t;

    // Mask of len bits starting at bit off, clipped at the word end.
    function automatic logic [WORD_BITS-1:0] span_mask(input logic [5:0] off,
                                                       input logic [6:0] len);
        logic [WORD_BITS:0] ones;
        begin
            ones = ({{WORD_BITS{1'b0}}, 1'b1} << len) - 1'b1;
            span_mask = ones[WORD_BITS-1:0] << off;
        end
    endfunction

endpackage

@@ rtl/bitmap_rectangle_allocator.sv @@
// Top level of the first-fit bitmap rectangle allocator.
// After reset the block clears its bitmap memory, one 64-bit word a cycle,
// while it holds in_stall high. A request then tests candidate corners in
// row-major order; each candidate reads and checks every bitmap word it
// touches, row by row, stopping at the first used cell, and placement marks
// each touched word with a read and a write. The single memory port pair sets
// the pace. One transfer is worked on at a time. The result sits in an output
// register, and the next request is accepted only once that register is
// empty or hands its result over in the same cycle.
module bitmap_rectangle_allocator
    import bra_pkg::*;
#(
    parameter int unsigned ATLAS_SIZE = ATLAS_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [8:0] rect_width,
    input  logic [8:0] rect_height,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       found,
    output logic [7:0] pos_x,
    output logic [7:0] pos_y
);

    localparam int unsigned CELLS = ATLAS_SIZE * ATLAS_SIZE;
    localparam int unsigned WORDS = (CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW    = $clog2(WORDS);
    localparam int unsigned CW    = $clog2(ATLAS_SIZE + 1);
    localparam int unsigned BW    = $clog2(CELLS);
    localparam int unsigned STEP  = (ATLAS_SIZE >= 8192) ? 4 : ((ATLAS_SIZE >= 4096) ? 2 : 1);

    bra_state_t       state_reg, state_next;
    logic [AW:0]      clr_reg, clr_next;
    logic [CW-1:0]    w_reg, w_next, h_reg, h_next;
    logic [CW-1:0]    x_reg, x_next, y_reg, y_next;
    logic [CW-1:0]    r_reg, r_next;      // row within rectangle
    logic [CW-1:0]    c_reg, c_next;      // cells already covered in the row
    logic             ovalid_reg, ovalid_next;
    logic             found_reg, found_next;
    logic [7:0]       px_reg, px_next, py_reg, py_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [63:0]      wr_data, rd_data;

    logic [CW-1:0]    row_y, col_x, left;
    logic [BW-1:0]    bit_addr;
    logic [5:0]       off;
    logic [6:0]       seg_len, room;
    logic [63:0]      mask;
    logic             row_last, rect_last, x_last, y_last;

    bra_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Current word segment of the rectangle.
    always_comb
    begin
        row_y    = y_reg + r_reg;
        col_x    = x_reg + c_reg;
        bit_addr = BW'(row_y) * BW'(ATLAS_SIZE) + BW'(col_x);
        off      = bit_addr[5:0];
        room     = 7'd64 - 7'(off);
        left     = w_reg - c_reg;
        seg_len  = (32'(room) < 32'(left)) ? room : 7'(left);
        mask     = span_mask(off, seg_len);
        row_last  = (CW'(seg_len) == left);
        rect_last = row_last && (r_reg == h_reg - 1'b1);
        x_last   = (x_reg + CW'(STEP)) > (CW'(ATLAS_SIZE) - w_reg);
        y_last   = (y_reg + CW'(STEP)) > (CW'(ATLAS_SIZE) - h_reg);
    end

    assign in_stall  = (state_reg != ST_IDLE) || (ovalid_reg && out_stall);
    assign out_valid = ovalid_reg;
    assign found     = found_reg;
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        ovalid_next = ovalid_reg && out_stall;
        found_next  = found_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        wr_en       = 1'b0;
        wr_addr     = bit_addr[BW-1:6];
        wr_data     = rd_data | mask;
        rd_addr     = bit_addr[BW-1:6];
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg[AW-1:0];
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    w_next = CW'(rect_width);
                    h_next = CW'(rect_height);
                    x_next = '0;
                    y_next = '0;
                    r_next = '0;
                    c_next = '0;
                    if (rect_width == 9'd0 || rect_height == 9'd0 ||
                        32'(rect_width) > ATLAS_SIZE || 32'(rect_height) > ATLAS_SIZE)
                    begin
                        found_next = 1'b0;
                        px_next    = '0;
                        py_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_TREAD;
                    end
                end
            end
            ST_TREAD:
            begin
                state_next = ST_TCHECK;
            end
            ST_TCHECK:
            begin
                if ((rd_data & mask) != '0)
                begin
                    r_next = '0;
                    c_next = '0;
                    if (!x_last)
                    begin
                        x_next     = x_reg + CW'(STEP);
                        state_next = ST_TREAD;
                    end
                    else if (!y_last)
                    begin
                        x_next     = '0;
                        y_next     = y_reg + CW'(STEP);
                        state_next = ST_TREAD;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        px_next    = '0;
                        py_next    = '0;
                        state_next = ST_DONE;
                    end
                end
                else if (rect_last)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = ST_MREAD;
                end
                else if (row_last)
                begin
                    r_next     = r_reg + 1'b1;
                    c_next     = '0;
                    state_next = ST_TREAD;
                end
                else
                begin
                    c_next     = c_reg + CW'(seg_len);
                    state_next = ST_TREAD;
                end
            end
            ST_MREAD:
            begin
                state_next = ST_MWRITE;
            end
            ST_MWRITE:
            begin
                wr_en = 1'b1;
                if (rect_last)
                begin
                    found_next = 1'b1;
                    px_next    = 8'(x_reg);
                    py_next    = 8'(y_reg);
                    state_next = ST_DONE;
                end
                else if (row_last)
                begin
                    r_next     = r_reg + 1'b1;
                    c_next     = '0;
                    state_next = ST_MREAD;
                end
                else
                begin
                    c_next     = c_reg + CW'(seg_len);
                    state_next = ST_MREAD;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        h_reg     <= h_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        found_reg <= found_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
    end

endmodule

@@ rtl/bra_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/bra_checker.sv @@
// Port-level checker for the rectangle allocator, bound to the top level.
module bra_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       found,
    input logic [7:0] pos_x,
    input logic [7:0] pos_y
);

    // A result that is not found reports the origin.
    a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (pos_x == 8'd0 && pos_y == 8'd0))
        else $error("not-found result with nonzero corner");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found) &&
                                      $stable(pos_x) && $stable(pos_y)))
        else $error("stalled result changed");

    // An accepted request is never answered in the next cycle.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

    // One request at a time: after a transfer the input stalls.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request accepted while busy");

endmodule

bind bitmap_rectangle_allocator bra_checker u_bra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .pos_x     (pos_x),
    .pos_y     (pos_y)
);
